### hw/rtl/tsc_pkg.sv
// Shared constants, types and the saturating accumulate for the Taylor sine/cosine block.
package tsc_pkg;

   localparam int ANGLE_W     = 32;
   localparam int MAG_W       = 62;
   localparam int ACC_W       = 64;
   localparam int RECIP_BITS  = 40;
   localparam int MUL_SLICE_W = 32;

   localparam logic [MAG_W-1:0] MAG_LIMIT = '1;

   localparam logic OP_SINE   = 1'b0;
   localparam logic OP_COSINE = 1'b1;

   typedef logic [MAG_W-1:0]        mag_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   // Series term in sign-magnitude form.
   typedef struct packed {
      logic    neg;
      mag_type mag;
   } term_type;

   // Adds a term to the accumulator and clips the sum to plus or minus MAG_LIMIT.
   function automatic acc_type sat_add(input acc_type acc, input term_type t);
      acc_type lim;
      acc_type addend;
      acc_type total;
      acc_type result;
      lim    = $signed(ACC_W'(MAG_LIMIT));
      addend = t.neg ? -$signed(ACC_W'(t.mag)) : $signed(ACC_W'(t.mag));
      total  = acc + addend;
      if (total > lim) begin
         result = lim;
      end else if (total < -lim) begin
         result = -lim;
      end else begin
         result = total;
      end
      return result;
   endfunction

endpackage

### hw/rtl/tsc_if.sv
// Request and response channel interfaces of the Taylor sine/cosine block.
interface tsc_req_if;
   import tsc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic signed [ANGLE_W-1:0] angle;
   modport source (output valid, output opcode, output angle, input ready);
   modport sink (input valid, input opcode, input angle, output ready);
endinterface

interface tsc_rsp_if;
   import tsc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] value;
   logic                      saturated;
   modport source (output valid, output value, output saturated, input ready);
   modport sink (input valid, input value, input saturated, output ready);
endinterface

### hw/rtl/tsc_mag_mul.sv
// Two-stage magnitude multiplier with round-half-up shift and clip to MAG_LIMIT.
module tsc_mag_mul #(
   parameter int A_W    = 62,
   parameter int B_W    = 40,
   parameter int SHIFT  = 40,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [A_W-1:0]    in_a,
   input  logic [B_W-1:0]    in_b,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output tsc_pkg::mag_type  out_mag,
   output logic [SIDE_W-1:0] out_side
);
   import tsc_pkg::*;

   localparam int S      = MUL_SLICE_W;
   localparam int AH_W   = A_W - S;
   localparam int BH_W   = B_W - S;
   localparam int PROD_W = A_W + B_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int RES_W  = SUM_W - SHIFT;
   localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (SHIFT - 1);

   logic                   pp_load;
   logic                   res_load;
   logic                   pp_valid_ff;
   logic [2*S-1:0]         pp00_in, pp00_ff;
   logic [S+BH_W-1:0]      pp01_in, pp01_ff;
   logic [AH_W+S-1:0]      pp10_in, pp10_ff;
   logic [AH_W+BH_W-1:0]   pp11_in, pp11_ff;
   logic [SIDE_W-1:0]      pp_side_ff;
   logic                   res_valid_ff;
   mag_type                res_in, res_ff;
   logic [SIDE_W-1:0]      res_side_ff;
   logic [SUM_W-1:0]       sum;
   logic [RES_W-1:0]       shifted;

   assign res_load = !res_valid_ff || out_ready;
   assign pp_load  = !pp_valid_ff || res_load;
   assign in_ready = pp_load;

   // Partial products of the split operands, each at most 32 by 32 bits.
   assign pp00_in = in_a[S-1:0] * in_b[S-1:0];
   assign pp01_in = in_a[S-1:0] * in_b[B_W-1:S];
   assign pp10_in = in_a[A_W-1:S] * in_b[S-1:0];
   assign pp11_in = in_a[A_W-1:S] * in_b[B_W-1:S];

   always_comb begin
      sum = SUM_W'(pp00_ff) + (SUM_W'(pp01_ff) << S) + (SUM_W'(pp10_ff) << S)
            + (SUM_W'(pp11_ff) << (2 * S)) + HALF;
      shifted = sum[SUM_W-1:SHIFT];
      res_in  = (shifted > RES_W'(MAG_LIMIT)) ? MAG_LIMIT : shifted[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         if (pp_load) begin
            pp_valid_ff <= in_valid;
         end
         if (res_load) begin
            res_valid_ff <= pp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pp_load) begin
         pp00_ff    <= pp00_in;
         pp01_ff    <= pp01_in;
         pp10_ff    <= pp10_in;
         pp11_ff    <= pp11_in;
         pp_side_ff <= in_side;
      end
      if (res_load) begin
         res_ff      <= res_in;
         res_side_ff <= pp_side_ff;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_mag   = res_ff;
   assign out_side  = res_side_ff;

   a_pp_advances: assert property (@(posedge clock) disable iff (reset)
      pp_valid_ff && res_load |=> res_valid_ff)
      else $error("partial products were dropped on the way to the result stage");

endmodule

### hw/rtl/tsc_front.sv
// Front end: angle magnitude, squaring and the first series term.
module tsc_front #(
   parameter int FRACTION_BITS = 28,
   localparam int SQ_W = tsc_pkg::MAG_W + 1 - FRACTION_BITS
) (
   input  logic              clock,
   input  logic              reset,
   tsc_req_if.sink           req_chan,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_is_cos,
   output tsc_pkg::term_type out_cur,
   output logic [SQ_W-1:0]   out_sq,
   output tsc_pkg::acc_type  out_acc
);
   import tsc_pkg::*;

   localparam int PROD_W = 2 * ANGLE_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic [SUM_W-1:0] HALF   = SUM_W'(1) << (FRACTION_BITS - 1);
   localparam logic [SQ_W-1:0]  SQ_MAX = SQ_W'(1) << (SQ_W - 1);

   logic                 load0, load1, load2;
   logic                 valid0_ff, valid1_ff, valid2_ff;
   logic                 cos0_ff, cos1_ff, cos2_ff;
   logic                 neg0_ff, neg1_ff;
   logic [ANGLE_W-1:0]   mag_in, mag0_ff, mag1_ff;
   logic [PROD_W-1:0]    prod_in, prod1_ff;
   logic [SUM_W-1:0]     round_sum;
   logic [SQ_W-1:0]      sq_in, sq2_ff;
   term_type             cur_in, cur2_ff;

   assign load2 = !valid2_ff || out_ready;
   assign load1 = !valid1_ff || load2;
   assign load0 = !valid0_ff || load1;
   assign req_chan.ready = load0;

   assign mag_in = req_chan.angle[ANGLE_W-1] ? $unsigned(-req_chan.angle)
                                             : $unsigned(req_chan.angle);
   assign prod_in = mag0_ff * mag0_ff;

   always_comb begin
      round_sum = SUM_W'(prod1_ff) + HALF;
      sq_in     = round_sum[FRACTION_BITS+SQ_W-1:FRACTION_BITS];
      if (cos1_ff == OP_COSINE) begin
         cur_in.neg = 1'b0;
         cur_in.mag = MAG_W'(1) << FRACTION_BITS;
      end else begin
         cur_in.neg = neg1_ff;
         cur_in.mag = MAG_W'(mag1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (load0) begin
            valid0_ff <= req_chan.valid;
         end
         if (load1) begin
            valid1_ff <= valid0_ff;
         end
         if (load2) begin
            valid2_ff <= valid1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load0) begin
         cos0_ff <= req_chan.opcode;
         neg0_ff <= req_chan.angle[ANGLE_W-1];
         mag0_ff <= mag_in;
      end
      if (load1) begin
         cos1_ff  <= cos0_ff;
         neg1_ff  <= neg0_ff;
         mag1_ff  <= mag0_ff;
         prod1_ff <= prod_in;
      end
      if (load2) begin
         cos2_ff <= cos1_ff;
         cur2_ff <= cur_in;
         sq2_ff  <= sq_in;
      end
   end

   assign out_valid  = valid2_ff;
   assign out_is_cos = cos2_ff;
   assign out_cur    = cur2_ff;
   assign out_sq     = sq2_ff;
   assign out_acc    = '0;

   a_sq_bound: assert property (@(posedge clock) disable iff (reset)
      valid2_ff |-> sq2_ff <= SQ_MAX)
      else $error("squared angle exceeds the square of the largest angle");

endmodule

### hw/rtl/tsc_term.sv
// One series step: accumulates the current term and forms the next one.
module tsc_term #(
   parameter int K             = 1,
   parameter int FRACTION_BITS = 28,
   localparam int SQ_W = tsc_pkg::MAG_W + 1 - FRACTION_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_is_cos,
   input  tsc_pkg::term_type in_cur,
   input  logic [SQ_W-1:0]   in_sq,
   input  tsc_pkg::acc_type  in_acc,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_is_cos,
   output tsc_pkg::term_type out_cur,
   output logic [SQ_W-1:0]   out_sq,
   output tsc_pkg::acc_type  out_acc
);
   import tsc_pkg::*;

   localparam longint unsigned DivSine   = 2 * K * (2 * K + 1);
   localparam longint unsigned DivCosine = 2 * K * (2 * K - 1);
   localparam longint unsigned RecipOne  = 64'd1 << RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_SINE =
      RECIP_BITS'((RecipOne + DivSine / 2) / DivSine);
   localparam logic [RECIP_BITS-1:0] RECIP_COSINE =
      RECIP_BITS'((RecipOne + DivCosine / 2) / DivCosine);

   typedef struct packed {
      logic            is_cos;
      logic            neg;
      logic [SQ_W-1:0] sq;
      acc_type         acc;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

   side_type                side_in, side1, side2;
   logic                    mid_valid, mid_ready;
   mag_type                 prod_mag, next_mag;
   logic [RECIP_BITS-1:0]   recip;

   always_comb begin
      side_in.is_cos = in_is_cos;
      side_in.neg    = in_cur.neg;
      side_in.sq     = in_sq;
      side_in.acc    = sat_add(in_acc, in_cur);
   end

   // Current term times the squared angle.
   tsc_mag_mul #(
      .A_W    (MAG_W),
      .B_W    (SQ_W),
      .SHIFT  (FRACTION_BITS),
      .SIDE_W (SIDE_W)
   ) u_sq_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_ready  (in_ready),
      .in_a      (in_cur.mag),
      .in_b      (in_sq),
      .in_side   (side_in),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_mag   (prod_mag),
      .out_side  (side1)
   );

   assign recip = (side1.is_cos == OP_COSINE) ? RECIP_COSINE : RECIP_SINE;

   // Division by the series denominator as a product with its reciprocal.
   tsc_mag_mul #(
      .A_W    (MAG_W),
      .B_W    (RECIP_BITS),
      .SHIFT  (RECIP_BITS),
      .SIDE_W (SIDE_W)
   ) u_recip_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_a      (prod_mag),
      .in_b      (recip),
      .in_side   (side1),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .out_mag   (next_mag),
      .out_side  (side2)
   );

   // The series alternates, so the next term has the opposite sign.
   assign out_is_cos  = side2.is_cos;
   assign out_cur.neg = ~side2.neg;
   assign out_cur.mag = next_mag;
   assign out_sq      = side2.sq;
   assign out_acc     = side2.acc;

endmodule

### hw/rtl/tsc_out.sv
// Final accumulate and clip of the series sum to the 32-bit response.
module tsc_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tsc_pkg::term_type in_cur,
   input  tsc_pkg::acc_type  in_acc,
   tsc_rsp_if.source         rsp_chan
);
   import tsc_pkg::*;

   localparam acc_type OUT_MAX = $signed(ACC_W'({1'b0, {(ANGLE_W - 1){1'b1}}}));
   localparam acc_type OUT_MIN = -OUT_MAX - 1;
   localparam logic [ANGLE_W-1:0] VALUE_MAX = {1'b0, {(ANGLE_W - 1){1'b1}}};
   localparam logic [ANGLE_W-1:0] VALUE_MIN = {1'b1, {(ANGLE_W - 1){1'b0}}};

   logic               sum_load, rsp_load;
   logic               sum_valid_ff, rsp_valid_ff;
   acc_type            sum_in, sum_ff;
   logic [ANGLE_W-1:0] value_in, value_ff;
   logic               sat_in, sat_ff;

   assign rsp_load = !rsp_valid_ff || rsp_chan.ready;
   assign sum_load = !sum_valid_ff || rsp_load;
   assign in_ready = sum_load;

   assign sum_in = sat_add(in_acc, in_cur);

   always_comb begin
      if (sum_ff > OUT_MAX) begin
         value_in = VALUE_MAX;
         sat_in   = 1'b1;
      end else if (sum_ff < OUT_MIN) begin
         value_in = VALUE_MIN;
         sat_in   = 1'b1;
      end else begin
         value_in = sum_ff[ANGLE_W-1:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (sum_load) begin
            sum_valid_ff <= in_valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sum_load) begin
         sum_ff <= sum_in;
      end
      if (rsp_load) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value     = $signed(value_ff);
   assign rsp_chan.saturated = sat_ff;

endmodule

### hw/rtl/taylor_sine_cosine.sv
// Top level of the pipelined Taylor-series sine and cosine unit.
// Each request carries an opcode (sine or cosine) and an angle in signed fixed point with
// FRACTION_BITS fraction bits; the response is the sum of TERM_COUNT Taylor terms in the same
// format, clipped to the 32-bit range with the saturated flag set when a clip happened. There
// is no range reduction, so accuracy falls off for angles far from zero. The unit is a fully
// pipelined datapath: a three-stage front end takes the magnitude of the angle and squares it,
// each of the TERM_COUNT-1 series steps is four stages (two pipelined multipliers, one by the
// squared angle and one by a constant reciprocal of the series denominator), and a two-stage
// back end adds the last term and clips. A new request can be accepted in every cycle
// unless the pipeline is full behind a stalled response side. Every stage carries its own
// valid bit and loads whenever it is empty or the stage after it moves, so when the response
// side stalls the pipeline keeps accepting requests until its empty slots are filled.
// Requests are independent and the block keeps no state between them.
module taylor_sine_cosine #(
   parameter int TERM_COUNT    = 10,
   parameter int FRACTION_BITS = 28
) (
   input  logic      clock,
   input  logic      reset,
   tsc_req_if.sink   req_chan,
   tsc_rsp_if.source rsp_chan
);
   import tsc_pkg::*;

   localparam int SQ_W = MAG_W + 1 - FRACTION_BITS;

   // Link k carries an item between series step k and step k+1; link 0 leaves the front end.
   logic            link_valid  [TERM_COUNT];
   logic            link_ready  [TERM_COUNT];
   logic            link_is_cos [TERM_COUNT];
   term_type        link_cur    [TERM_COUNT];
   logic [SQ_W-1:0] link_sq     [TERM_COUNT];
   acc_type         link_acc    [TERM_COUNT];

   tsc_front #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .out_valid  (link_valid[0]),
      .out_ready  (link_ready[0]),
      .out_is_cos (link_is_cos[0]),
      .out_cur    (link_cur[0]),
      .out_sq     (link_sq[0]),
      .out_acc    (link_acc[0])
   );

   // One step per later term; step k builds term k from term k-1.
   for (genvar k = 1; k < TERM_COUNT; k++) begin : g_term
      tsc_term #(
         .K             (k),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_term (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (link_valid[k-1]),
         .in_ready   (link_ready[k-1]),
         .in_is_cos  (link_is_cos[k-1]),
         .in_cur     (link_cur[k-1]),
         .in_sq      (link_sq[k-1]),
         .in_acc     (link_acc[k-1]),
         .out_valid  (link_valid[k]),
         .out_ready  (link_ready[k]),
         .out_is_cos (link_is_cos[k]),
         .out_cur    (link_cur[k]),
         .out_sq     (link_sq[k]),
         .out_acc    (link_acc[k])
      );
   end

   // The last term is added and the sum clipped to the response format.
   tsc_out u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (link_valid[TERM_COUNT-1]),
      .in_ready (link_ready[TERM_COUNT-1]),
      .in_cur   (link_cur[TERM_COUNT-1]),
      .in_acc   (link_acc[TERM_COUNT-1]),
      .rsp_chan (rsp_chan)
   );

   // Reset empties the whole pipeline, so no response can follow it directly.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

   // A clipped response must sit at one of the two ends of the output range.
   a_sat_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.saturated |->
         (rsp_chan.value == 32'sh7FFFFFFF || rsp_chan.value == 32'sh80000000))
      else $error("saturated response is not at a range end");

endmodule

### bench/taylor_sine_cosine_tb.sv
// Self-checking testbench for the pipelined Taylor-series sine and cosine unit.
`timescale 1ns / 100ps

module taylor_sine_cosine_tb;
   import tsc_pkg::*;

   localparam int TERM_COUNT    = 10;
   localparam int FRACTION_BITS = 28;

   // Unstalled latency of the pipeline, reckoned from the stage counts of its parts.
   localparam int PIPE_LATENCY = 3 + 4 * (TERM_COUNT - 1) + 2;

   localparam int RANDOM_COUNT = 600;
   localparam int QUIET_TAIL   = 100;
   localparam int LONG_HOLD    = 300;

   // Handy angles in Q4.28.
   localparam logic signed [31:0] ONE_Q     = 32'sh1000_0000;
   localparam logic signed [31:0] HALF_PI_Q = 32'sh1921_FB54;
   localparam logic signed [31:0] PI_Q      = 32'sh3243_F6A9;
   localparam logic signed [31:0] FOUR_Q    = 32'sh4000_0000;
   localparam logic signed [31:0] TOP_Q     = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] BOTTOM_Q  = 32'sh8000_0000;

   localparam longint INT32_TOP    = 64'sd2147483647;
   localparam longint INT32_BOTTOM = -64'sd2147483648;

   typedef struct {
      logic                opcode;
      logic signed [31:0]  angle;
      logic signed [31:0]  value;
      logic                saturated;
   } series_result_type;

   // Predicts the series sum for each accepted request and compares responses in order.
   class series_scoreboard_type;
      series_result_type pending_sums[$];
      int                failures;

      function new();
         failures = 0;
      endfunction

      // Magnitude product (a*b) >> sh, rounded half up and clipped to the magnitude limit.
      function logic [63:0] mag_product(logic [63:0] a, logic [63:0] b, int unsigned sh);
         logic [127:0] full;
         logic [127:0] ceiling;
         ceiling = {66'd0, MAG_LIMIT};
         full = ({64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1))) >> sh;
         if (full > ceiling) begin
            return ceiling[63:0];
         end
         return full[63:0];
      endfunction

      // Signed product with rounding half away from zero, so sine stays odd and cosine even.
      function longint scaled_product(longint a, longint b, int unsigned sh);
         logic        negative;
         logic [63:0] ma;
         logic [63:0] mb;
         longint      m;
         negative = (a < 0) != (b < 0);
         ma = (a < 0) ? -a : a;
         mb = (b < 0) ? -b : b;
         m = longint'(mag_product(ma, mb, sh));
         return negative ? -m : m;
      endfunction

      function longint clip_add(longint a, longint b);
         longint total;
         longint lim;
         lim = longint'({2'b00, MAG_LIMIT});
         total = a + b;
         if (total > lim) begin
            return lim;
         end else if (total < -lim) begin
            return -lim;
         end
         return total;
      endfunction

      function longint reciprocal(longint d);
         return ((longint'(1) <<< RECIP_BITS) + d / 2) / d;
      endfunction

      function series_result_type series_sum(logic opcode, logic signed [31:0] angle);
         series_result_type r;
         longint            x;
         longint            square;
         longint            term;
         longint            acc;
         longint            k;
         longint            d;
         longint            p;
         x = longint'(angle);
         square = scaled_product(x, x, FRACTION_BITS);
         term = (opcode == OP_COSINE) ? (longint'(1) <<< FRACTION_BITS) : x;
         acc = 0;
         for (int i = 0; i < TERM_COUNT; i++) begin
            acc = clip_add(acc, term);
            if (i + 1 < TERM_COUNT) begin
               k = i + 1;
               d = (opcode == OP_COSINE) ? (2 * k) * (2 * k - 1) : (2 * k) * (2 * k + 1);
               p = scaled_product(term, square, FRACTION_BITS);
               term = -scaled_product(p, reciprocal(d), RECIP_BITS);
            end
         end
         r.opcode = opcode;
         r.angle = angle;
         r.saturated = 1'b0;
         if (acc > INT32_TOP) begin
            acc = INT32_TOP;
            r.saturated = 1'b1;
         end else if (acc < INT32_BOTTOM) begin
            acc = INT32_BOTTOM;
            r.saturated = 1'b1;
         end
         r.value = acc[31:0];
         return r;
      endfunction

      function void note_request(logic opcode, logic signed [31:0] angle);
         pending_sums.push_back(series_sum(opcode, angle));
      endfunction

      function void check_response(logic signed [31:0] value, logic saturated);
         series_result_type want;
         if (pending_sums.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("ERROR: response with nothing pending: value=%h saturated=%b",
                        value, saturated);
            end
            return;
         end
         want = pending_sums.pop_front();
         if (value !== want.value || saturated !== want.saturated) begin
            failures++;
            if (failures <= 10) begin
               $display({"ERROR: op=%b angle=%h expected value=%h saturated=%b,",
                         " got value=%h saturated=%b"},
                        want.opcode, want.angle, want.value, want.saturated, value, saturated);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tsc_req_if req_chan ();
   tsc_rsp_if rsp_chan ();

   taylor_sine_cosine #(
      .TERM_COUNT    (TERM_COUNT),
      .FRACTION_BITS (FRACTION_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   series_scoreboard_type board = new();

   int   requests_accepted = 0;
   logic quiet_phase;   // No idling on either side once this is set.
   logic hold_rsp;      // The long response hold-off that backs the pipeline up.

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offers one request and waits for the edge at which it is taken. The valid is left high so
   // that a following request can go out back to back without a drop.
   task automatic send_request(logic opcode, logic signed [31:0] angle);
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= opcode;
      req_chan.angle  <= angle;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      board.note_request(opcode, angle);
      requests_accepted++;
   endtask

   // Drops valid for a random burst of idle cycles.
   task automatic idle_sender(int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Mixes full-range angles with ones in the useful range around zero and ones near the ends.
   function automatic logic signed [31:0] pick_angle();
      logic signed [31:0] a;
      case ($urandom_range(0, 3))
         0: a = $urandom;
         1: a = $signed($urandom_range(0, 32'h6487_ED52)) - PI_Q;
         2: a = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
         default: begin
            if ($urandom_range(0, 1)) begin
               a = TOP_Q - $signed($urandom_range(0, 32'h00FF_FFFF));
            end else begin
               a = BOTTOM_Q + $signed($urandom_range(0, 32'h00FF_FFFF));
            end
         end
      endcase
      return a;
   endfunction

   // Request side: reset, the directed requests, then the random ones, then the drain.
   initial begin
      logic signed [31:0] directed_angles[$];
      logic               op;
      int                 gap;

      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.opcode <= OP_SINE;
      req_chan.angle  <= '0;
      quiet_phase     <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero, one step either side of zero, the two ends of the range, and the usual
      // landmarks of a quarter turn, a half turn, one and four.
      directed_angles = '{32'sd0, 32'sd1, -32'sd1, TOP_Q, BOTTOM_Q, HALF_PI_Q, -HALF_PI_Q,
                          PI_Q, -PI_Q, ONE_Q, FOUR_Q, -FOUR_Q};
      foreach (directed_angles[i]) begin
         send_request(OP_SINE, directed_angles[i]);
         send_request(OP_COSINE, directed_angles[i]);
      end

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         op = $urandom_range(0, 1) ? OP_COSINE : OP_SINE;
         send_request(op, pick_angle());
         if (i == RANDOM_COUNT - QUIET_TAIL) begin
            quiet_phase <= 1'b1;
         end
         // Idle bursts only come in some stretches, so that runs of back-to-back requests
         // alternate with gappy ones.
         if (i < RANDOM_COUNT - QUIET_TAIL && (i / 40) % 3 != 0 && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            idle_sender(gap);
         end
      end
      req_chan.valid <= 1'b0;

      // Wait for every pending result, then give the pipeline time to show any stray response.
      while (board.pending_sums.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      if (board.failures == 0 && board.pending_sums.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Response side: checks every accepted response and stalls in random bursts.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      do begin
         @(posedge clock);
      end while (reset);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            board.check_response(rsp_chan.value, rsp_chan.saturated);
         end
         if (stall_left == 0 && !quiet_phase && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 12);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !hold_rsp;
         end
      end
   end

   // Once the random requests are under way, the response side holds off far longer than the
   // pipeline is deep, so the block fills up and has to stall its request side.
   initial begin
      hold_rsp <= 1'b0;
      while (requests_accepted < 80) begin
         @(posedge clock);
      end
      hold_rsp <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Guards against a hang; far beyond the slowest correct run.
   initial begin
      #800000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
